// ===== hw/rtl/modbus_sensor_poller_defines.svh =====
// Assertion macros for the sensor poller checker.
`ifndef MODBUS_SENSOR_POLLER_DEFINES_SVH
`define MODBUS_SENSOR_POLLER_DEFINES_SVH

// same-cycle implication
`define MSP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("msp_checker: property violated");

// next-cycle implication
`define MSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("msp_checker: property violated");

`endif

// ===== hw/rtl/msp_pkg.sv =====
// Types, register indexes and constants shared by the sensor poller.
package msp_pkg;

  parameter int unsigned DefTimeWidth = 16;

  localparam int unsigned ScaledWidth = 23;
  localparam int unsigned Scale       = 100;

  localparam logic [7:0] FuncReadHolding  = 8'd3;
  localparam logic [7:0] MaxAddress       = 8'd247;
  localparam logic [7:0] MissedMax        = 8'hFF;
  localparam logic [7:0] MissedLimitReset = 8'd3;
  localparam logic [7:0] LenTemperature   = 8'd2;
  localparam logic [7:0] LenPressure      = 8'd4;
  localparam logic [7:0] LenHumidity      = 8'd6;

  typedef enum logic {
    CMD_TICK     = 1'b0,
    CMD_RESPONSE = 1'b1
  } cmd_e;

  typedef enum logic [7:0] {
    REG_DEVICE_ADDRESS = 8'd0,
    REG_CONVERT_WAIT   = 8'd1,
    REG_RETRY_WAIT     = 8'd2,
    REG_MISSED_LIMIT   = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0]  reg_index;
    logic [31:0] wdata;
  } msp_cfg_wr_t;

  typedef struct packed {
    logic [7:0]  device_address;
    logic [15:0] convert_wait;
    logic [15:0] retry_wait;
    logic [7:0]  missed_limit;
  } msp_cfg_t;

  typedef struct packed {
    logic        command;
    logic        bus_ready;
    logic [7:0]  resp_address;
    logic [7:0]  resp_function;
    logic [7:0]  resp_length;
    logic [15:0] word_temperature;
    logic [15:0] word_pressure;
    logic [15:0] word_humidity;
  } msp_in_t;

  typedef struct packed {
    logic                   send_request;
    logic [7:0]             request_address;
    logic                   link_error;
    logic [ScaledWidth-1:0] temperature_scaled;
    logic [ScaledWidth-1:0] pressure_scaled;
    logic [ScaledWidth-1:0] humidity_scaled;
  } msp_out_t;

endpackage

// ===== hw/rtl/msp_stream_if.sv =====
// Valid/ready stream interface carrying one payload beat.
interface msp_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/msp_cfg_regs.sv =====
// Configuration register file of the sensor poller.
module msp_cfg_regs import msp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  msp_stream_if.sink   cfg_i,
  output msp_cfg_t     cfg_o
);

  msp_cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_address <= '0;
      cfg_q.convert_wait   <= '0;
      cfg_q.retry_wait     <= '0;
      cfg_q.missed_limit   <= MissedLimitReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.reg_index)
        REG_DEVICE_ADDRESS: cfg_q.device_address <= cfg_i.data.wdata[7:0];
        REG_CONVERT_WAIT:   cfg_q.convert_wait   <= cfg_i.data.wdata[15:0];
        REG_RETRY_WAIT:     cfg_q.retry_wait     <= cfg_i.data.wdata[15:0];
        REG_MISSED_LIMIT:   cfg_q.missed_limit   <= cfg_i.data.wdata[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/msp_core.sv =====
// Input register, poll state update and result register of the sensor poller.
module msp_core import msp_pkg::*; #(
  parameter int unsigned TimeWidth = DefTimeWidth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  msp_cfg_t     cfg_i,
  msp_stream_if.sink   in_i,
  msp_stream_if.source out_o
);

  logic                 in_valid_q;
  msp_in_t              in_data_q;
  logic                 out_valid_q;
  msp_out_t             out_data_q;
  msp_out_t             out_d;
  logic                 advance;

  logic [TimeWidth-1:0] countdown_q, countdown_d, countdown_dec;
  logic [7:0]           missed_q, missed_d;
  logic [15:0]          raw_temp_q, raw_temp_d;
  logic [15:0]          raw_pres_q, raw_pres_d;
  logic [15:0]          raw_hum_q, raw_hum_d;
  logic                 configured;
  logic                 is_tick;
  logic                 resp_match;
  logic                 resp_read;
  logic                 send;

  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_data_q <= in_i.data;
    end
  end

  always_comb begin
    configured    = (cfg_i.device_address != '0) && (cfg_i.device_address <= MaxAddress);
    is_tick       = (in_data_q.command == CMD_TICK);
    resp_match    = !is_tick && configured && (in_data_q.resp_address == cfg_i.device_address);
    resp_read     = resp_match && (in_data_q.resp_function == FuncReadHolding);
    countdown_dec = (countdown_q != '0) ? countdown_q - TimeWidth'(1) : countdown_q;
    send          = is_tick && (countdown_dec == '0) && in_data_q.bus_ready && configured;

    countdown_d = countdown_q;
    missed_d    = missed_q;
    raw_temp_d  = raw_temp_q;
    raw_pres_d  = raw_pres_q;
    raw_hum_d   = raw_hum_q;

    if (is_tick) begin
      countdown_d = send ? TimeWidth'(cfg_i.retry_wait) : countdown_dec;
      if (send && (missed_q != MissedMax)) begin
        missed_d = missed_q + 8'd1;
      end
    end else if (resp_match) begin
      missed_d = '0;
      if (resp_read) begin
        countdown_d = TimeWidth'(cfg_i.convert_wait);
        if (in_data_q.resp_length >= LenTemperature) raw_temp_d = in_data_q.word_temperature;
        if (in_data_q.resp_length >= LenPressure)    raw_pres_d = in_data_q.word_pressure;
        if (in_data_q.resp_length >= LenHumidity)    raw_hum_d  = in_data_q.word_humidity;
      end
    end

    out_d.send_request       = send;
    out_d.request_address    = send ? cfg_i.device_address : '0;
    out_d.link_error         = (missed_d > cfg_i.missed_limit);
    out_d.temperature_scaled = ScaledWidth'(raw_temp_d) * ScaledWidth'(Scale);
    out_d.pressure_scaled    = ScaledWidth'(raw_pres_d) * ScaledWidth'(Scale);
    out_d.humidity_scaled    = ScaledWidth'(raw_hum_d) * ScaledWidth'(Scale);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      countdown_q <= '0;
      missed_q    <= '0;
      raw_temp_q  <= '0;
      raw_pres_q  <= '0;
      raw_hum_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        countdown_q <= countdown_d;
        missed_q    <= missed_d;
        raw_temp_q  <= raw_temp_d;
        raw_pres_q  <= raw_pres_d;
        raw_hum_q   <= raw_hum_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_d;
    end
  end

endmodule

// ===== hw/rtl/modbus_sensor_poller.sv =====
// Top level of the atmosphere sensor poller.
// An accepted input beat passes through the input register and then the result register.
// Throughput: one tick or response per cycle while the result output is not stalled.
// A stalled result holds in the result register while one more input waits in the input register.
// Reset clears poll countdown, missed count and latched values; missed_limit resets to 3.
// Configuration writes are taken every cycle, also right after reset.
module modbus_sensor_poller import msp_pkg::*; #(
  parameter int unsigned TimeWidth = DefTimeWidth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  msp_stream_if.sink   cfg_i,
  msp_stream_if.sink   in_i,
  msp_stream_if.source out_o
);

  msp_cfg_t cfg;

  msp_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  msp_core #(
    .TimeWidth (TimeWidth)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule

// ===== hw/rtl/msp_checker.sv =====
// Port-level checker for the sensor poller and its bind.
`include "modbus_sensor_poller_defines.svh"

module msp_checker import msp_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     out_valid_i,
  input logic     out_ready_i,
  input msp_out_t out_data_i
);

  `MSP_ASSERT_SAME(a_req_addr_legal, clk_i, rst_ni, out_valid_i && out_data_i.send_request, out_data_i.request_address != '0 && out_data_i.request_address <= MaxAddress)
  `MSP_ASSERT_SAME(a_idle_addr_zero, clk_i, rst_ni, out_valid_i && !out_data_i.send_request, out_data_i.request_address == '0)
  `MSP_ASSERT_NEXT(a_hold_valid, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `MSP_ASSERT_NEXT(a_hold_data, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_data_i))

endmodule

bind modbus_sensor_poller msp_checker u_msp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
